FILE: design/formant_filter_chain_defines.svh
// Assertion macros used by the checker file.
`ifndef FORMANT_FILTER_CHAIN_DEFINES_SVH
`define FORMANT_FILTER_CHAIN_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define FFC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define FFC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ffc_pkg.sv
`timescale 1ns / 1ps
package ffc_pkg;

	localparam int NUM_RESONATORS_DEF = 5;
	localparam int SAMPLE_BITS        = 24;
	localparam int COEF_BITS          = 32;
	localparam int STATE_BITS         = 48;
	localparam int ACC_BITS           = 50;
	localparam int MIX_BITS           = 17;
	localparam int INDEX_BITS         = 6;
	localparam int CFG_INDEX_BITS     = 1;
	localparam int MAX_SECTIONS       = 10;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_WAH_MIX     = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FORMANT_MIX = 1'd1;

	localparam logic [MIX_BITS-1:0] MIX_ONE       = 17'd65536;
	localparam logic [MIX_BITS-1:0] WAH_MIX_RST   = 17'd52429;
	localparam logic [MIX_BITS-1:0] FMT_MIX_RST   = 17'd62259;
	localparam logic [COEF_BITS-1:0] COEF_UNITY   = 32'h0400_0000;
	localparam logic [COEF_BITS-1:0] COEF_DRIVE10 = 32'h2800_0000;

	localparam logic signed [STATE_BITS-1:0] ONE_I     = 48'sd16777216;
	localparam logic signed [STATE_BITS-1:0] NEG_ONE_I = -48'sd16777216;

	typedef logic signed [STATE_BITS-1:0] state_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_START,
		ST_WAIT,
		ST_WR1,
		ST_WR2,
		ST_OUT
	} seq_state_t;

	typedef enum logic [3:0] {
		OP_DRIVE,
		OP_B0,
		OP_B1,
		OP_A1,
		OP_B2,
		OP_A2,
		OP_WAH_DRY,
		OP_WAH_WET,
		OP_FMT_DRY,
		OP_FMT_WET
	} op_t;

	typedef enum logic [2:0] {
		MS_IDLE,
		MS_LO,
		MS_HI,
		MS_ACC,
		MS_RND
	} mul_state_t;

	typedef struct packed {
		logic                   start;
		logic                   mix_shift;
		logic signed [32:0]     a;
		logic signed [STATE_BITS-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                   done;
		logic signed [STATE_BITS-1:0] p;
	} mul_rsp_t;

	function automatic state_word_t sat48(input logic signed [ACC_BITS-1:0] v);
		if ((v[49] == v[48]) && (v[48] == v[47]))
			return v[47:0];
		return v[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
	endfunction

	function automatic state_word_t clip1(input state_word_t v);
		if (v > ONE_I)
			return ONE_I;
		if (v < NEG_ONE_I)
			return NEG_ONE_I;
		return v;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] to_sample(input state_word_t v);
		state_word_t c;
		logic signed [STATE_BITS:0] t;
		c = clip1(v);
		t = ($signed({c[STATE_BITS-1], c}) + 49'sd1) >>> 1;
		if (t > 49'sd8388607)
			return 24'h7F_FFFF;
		return t[SAMPLE_BITS-1:0];
	endfunction

	// Reset contents of the coefficient table: unity b0 per section, drive ten.
	function automatic logic [COEF_BITS-1:0] coef_default(input logic [INDEX_BITS-1:0] idx,
			input int nsec);
		logic [COEF_BITS-1:0] r;
		r = '0;
		for (int s = 0; s < MAX_SECTIONS; s++) begin
			if ((s < nsec) && (idx == INDEX_BITS'(5 * s)))
				r = COEF_UNITY;
		end
		if (idx == INDEX_BITS'(5 * nsec))
			r = COEF_DRIVE10;
		return r;
	endfunction

endpackage

FILE: design/ffc_ram.sv
`timescale 1ns / 1ps
module ffc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: design/ffc_mul.sv
`timescale 1ns / 1ps
module ffc_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  ffc_pkg::mul_req_t req,
	output ffc_pkg::mul_rsp_t rsp
);
	import ffc_pkg::*;

	mul_state_t  state_q;
	logic        done_q;
	logic        neg_q;
	logic        mix_q;
	logic [31:0] ma_q;
	logic [47:0] mb_q;
	logic [55:0] plo_q;
	logic [55:0] phi_q;
	logic [79:0] prod_q;
	state_word_t p_q;

	logic [32:0] a_mag;
	logic [47:0] b_mag;
	logic [80:0] rnd;
	logic [80:0] quo;
	logic [80:0] lim;
	logic [47:0] mag;

	assign a_mag = req.a[32] ? 33'(-req.a) : 33'(req.a);
	assign b_mag = req.b[47] ? 48'(-req.b) : 48'(req.b);

	// Round half away from zero on the magnitude, then saturate.
	always_comb begin
		rnd = {1'b0, prod_q} + (mix_q ? 81'd32768 : 81'd33554432);
		quo = mix_q ? (rnd >> 16) : (rnd >> 26);
		lim = neg_q ? {33'd0, 1'b1, 47'd0} : {34'd0, {47{1'b1}}};
		mag = (quo > lim) ? lim[47:0] : quo[47:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MS_IDLE: if (req.start) state_q <= MS_LO;
				MS_LO:   state_q <= MS_HI;
				MS_HI:   state_q <= MS_ACC;
				MS_ACC:  state_q <= MS_RND;
				MS_RND: begin
					state_q <= MS_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= MS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MS_IDLE: begin
				if (req.start) begin
					ma_q  <= a_mag[31:0];
					mb_q  <= b_mag;
					neg_q <= req.a[32] ^ req.b[47];
					mix_q <= req.mix_shift;
				end
			end
			MS_LO:  plo_q  <= ma_q * mb_q[23:0];
			MS_HI:  phi_q  <= ma_q * mb_q[47:24];
			MS_ACC: prod_q <= {24'd0, plo_q} + {phi_q, 24'd0};
			MS_RND: p_q    <= neg_q ? 48'(-mag) : mag;
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.p    = p_q;

endmodule

FILE: design/formant_filter_chain.sv
`timescale 1ns / 1ps
// Stereo formant filter chain: drive and clip, high shelf, wah with blend, a cascade of
// NUM_RESONATORS resonators, and a final blend with the undriven input, all per channel
// with 48-bit state. Every product goes through one shared multiply-round unit after
// its coefficient read, and each section then stores its delay pair through the single
// write port of the delay memory. A sample item is worked to its result before the
// input is ready again; a coefficient-write item leaves the input ready.
// The input is not ready while an item is in work; a finished result waits in the output
// register. Coefficients and delays live in RAMs whose unwritten words read as their reset
// values, so no clearing pass follows reset.
module formant_filter_chain #(
	parameter int NUM_RESONATORS = ffc_pkg::NUM_RESONATORS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_write,
	input  logic [ffc_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [ffc_pkg::MIX_BITS-1:0]              cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic                                      operation,
	input  logic signed [ffc_pkg::SAMPLE_BITS-1:0]    left_sample,
	input  logic signed [ffc_pkg::SAMPLE_BITS-1:0]    right_sample,
	input  logic [ffc_pkg::INDEX_BITS-1:0]            coef_index,
	input  logic signed [ffc_pkg::COEF_BITS-1:0]      coef_value,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [ffc_pkg::SAMPLE_BITS-1:0]    left_out,
	output logic signed [ffc_pkg::SAMPLE_BITS-1:0]    right_out
);
	import ffc_pkg::*;

	localparam int NSEC        = NUM_RESONATORS + 2;
	localparam int TABLE_WORDS = 5 * NSEC + 1;
	localparam int DLY_WORDS   = 4 * NSEC;
	localparam int COEF_AW     = $clog2(TABLE_WORDS);
	localparam int DLY_AW      = $clog2(DLY_WORDS);
	localparam int SEC_W       = $clog2(NSEC);

	seq_state_t state_q, state_d;
	op_t        op_q;
	logic [SEC_W-1:0] sec_q;
	logic       ch_q;

	logic [MIX_BITS-1:0] wah_mix_q, formant_mix_q;
	logic [TABLE_WORDS-1:0] coef_vld_q;
	logic [DLY_WORDS-1:0]   dly_vld_q;
	logic coef_rv_q, dly_rv_q;
	logic [COEF_BITS-1:0] coef_def_q;

	logic               coef_we;
	logic [COEF_AW-1:0] coef_waddr, coef_raddr;
	logic [COEF_BITS-1:0] coef_rdata, coef_val;
	logic [2:0]         coef_k;

	logic              dly_we;
	logic [DLY_AW-1:0] dly_base, dly_waddr, dly_raddr;
	state_word_t       dly_wdata;
	logic [STATE_BITS-1:0] dly_rdata;

	logic [SAMPLE_BITS-1:0] samp_q [2];
	logic [SAMPLE_BITS-1:0] res_q [2];
	logic [SAMPLE_BITS-1:0] left_q, right_q;
	logic        out_valid_q;
	state_word_t x_q, y_q, z_q, n1_q, n2_q, xin;
	logic signed [ACC_BITS-1:0] acc_q;
	logic signed [ACC_BITS-1:0] p_ext, z_ext;

	logic [MIX_BITS-1:0] wah_w, fmt_w, mixf;
	logic is_mix;
	logic accept_smp, accept_wr, done_ev, out_free;

	mul_req_t mreq;
	mul_rsp_t mrsp;

	assign accept_smp = (state_q == ST_IDLE) && in_valid && !operation;
	assign accept_wr  = (state_q == ST_IDLE) && in_valid && operation;
	assign done_ev    = (state_q == ST_WAIT) && mrsp.done;
	assign out_free   = !out_valid_q || out_ready;

	assign xin   = {{(STATE_BITS-SAMPLE_BITS-1){samp_q[ch_q][SAMPLE_BITS-1]}}, samp_q[ch_q], 1'b0};
	assign p_ext = {{2{mrsp.p[STATE_BITS-1]}}, mrsp.p};
	assign z_ext = {{2{z_q[STATE_BITS-1]}}, z_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept_smp) state_d = ST_READ;
			ST_READ:  state_d = ST_START;
			ST_START: state_d = ST_WAIT;
			ST_WAIT: begin
				if (mrsp.done) begin
					if (op_q == OP_A2)
						state_d = ST_WR1;
					else if ((op_q == OP_FMT_WET) && ch_q)
						state_d = ST_OUT;
					else
						state_d = ST_READ;
				end
			end
			ST_WR1:   state_d = ST_WR2;
			ST_WR2:   state_d = ST_READ;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: input ready, memory addresses and controls, and the multiply request.
	always_comb begin
		in_ready = (state_q == ST_IDLE);

		case (op_q)
			OP_B1:   coef_k = 3'd1;
			OP_A1:   coef_k = 3'd3;
			OP_B2:   coef_k = 3'd2;
			OP_A2:   coef_k = 3'd4;
			default: coef_k = 3'd0;
		endcase
		if (op_q == OP_DRIVE)
			coef_raddr = COEF_AW'(5 * NSEC);
		else
			coef_raddr = COEF_AW'({sec_q, 2'b00}) + COEF_AW'(sec_q) + COEF_AW'(coef_k);
		coef_we    = accept_wr && (coef_index < INDEX_BITS'(TABLE_WORDS));
		coef_waddr = coef_index[COEF_AW-1:0];
		coef_val   = coef_rv_q ? coef_rdata : coef_def_q;

		dly_base  = ch_q ? DLY_AW'(2 * NSEC) : '0;
		dly_raddr = dly_base + DLY_AW'({sec_q, (op_q == OP_B1)});
		dly_waddr = dly_base + DLY_AW'({sec_q, (state_q == ST_WR2)});
		dly_we    = (state_q == ST_WR1) || (state_q == ST_WR2);
		dly_wdata = (state_q == ST_WR2) ? n2_q : n1_q;

		wah_w = (wah_mix_q > MIX_ONE) ? MIX_ONE : wah_mix_q;
		fmt_w = (formant_mix_q > MIX_ONE) ? MIX_ONE : formant_mix_q;
		case (op_q)
			OP_WAH_DRY: mixf = MIX_ONE - wah_w;
			OP_WAH_WET: mixf = wah_w;
			OP_FMT_DRY: mixf = MIX_ONE - fmt_w;
			OP_FMT_WET: mixf = fmt_w;
			default:    mixf = '0;
		endcase
		is_mix = op_q inside {OP_WAH_DRY, OP_WAH_WET, OP_FMT_DRY, OP_FMT_WET};

		mreq.start     = (state_q == ST_START);
		mreq.mix_shift = is_mix;
		mreq.a = is_mix ? $signed({16'd0, mixf}) : $signed({coef_val[COEF_BITS-1], coef_val});
		case (op_q)
			OP_DRIVE, OP_FMT_DRY:        mreq.b = xin;
			OP_B0, OP_B1, OP_B2:         mreq.b = x_q;
			OP_WAH_DRY:                  mreq.b = x_q;
			OP_A1, OP_A2:                mreq.b = y_q;
			OP_WAH_WET, OP_FMT_WET:      mreq.b = y_q;
			default:                     mreq.b = x_q;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			op_q          <= OP_DRIVE;
			sec_q         <= '0;
			ch_q          <= 1'b0;
			out_valid_q   <= 1'b0;
			coef_vld_q    <= '0;
			dly_vld_q     <= '0;
			wah_mix_q     <= WAH_MIX_RST;
			formant_mix_q <= FMT_MIX_RST;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				case (cfg_index)
					CFG_WAH_MIX:     wah_mix_q     <= cfg_data;
					CFG_FORMANT_MIX: formant_mix_q <= cfg_data;
					default: ;
				endcase
			end
			if (coef_we)
				coef_vld_q[coef_waddr] <= 1'b1;
			if (dly_we)
				dly_vld_q[dly_waddr] <= 1'b1;
			if (accept_smp) begin
				op_q  <= OP_DRIVE;
				ch_q  <= 1'b0;
				sec_q <= '0;
			end
			if (done_ev) begin
				case (op_q)
					OP_DRIVE: begin
						op_q  <= OP_B0;
						sec_q <= '0;
					end
					OP_B0:      op_q <= OP_B1;
					OP_B1:      op_q <= OP_A1;
					OP_A1:      op_q <= OP_B2;
					OP_B2:      op_q <= OP_A2;
					OP_WAH_DRY: op_q <= OP_WAH_WET;
					OP_WAH_WET: begin
						op_q  <= OP_B0;
						sec_q <= SEC_W'(2);
					end
					OP_FMT_DRY: op_q <= OP_FMT_WET;
					OP_FMT_WET: begin
						op_q <= OP_DRIVE;
						ch_q <= 1'b1;
					end
					default: ;
				endcase
			end
			// Pick the next step once both delays of a section are stored.
			if (state_q == ST_WR2) begin
				if (sec_q == SEC_W'(1))
					op_q <= OP_WAH_DRY;
				else if (sec_q == SEC_W'(NSEC - 1))
					op_q <= OP_FMT_DRY;
				else begin
					op_q  <= OP_B0;
					sec_q <= sec_q + SEC_W'(1);
				end
			end
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		coef_rv_q  <= coef_vld_q[coef_raddr];
		coef_def_q <= coef_default(INDEX_BITS'(coef_raddr), NSEC);
		dly_rv_q   <= dly_vld_q[dly_raddr];
		if (accept_smp) begin
			samp_q[0] <= left_sample;
			samp_q[1] <= right_sample;
		end
		if (state_q == ST_START)
			z_q <= dly_rv_q ? dly_rdata : '0;
		if (done_ev) begin
			case (op_q)
				OP_DRIVE:   x_q   <= clip1(mrsp.p);
				OP_B0:      y_q   <= sat48(p_ext + z_ext);
				OP_B1:      acc_q <= p_ext + z_ext;
				OP_A1:      n1_q  <= sat48(acc_q - p_ext);
				OP_B2:      acc_q <= p_ext;
				OP_A2:      n2_q  <= sat48(acc_q - p_ext);
				OP_WAH_DRY: acc_q <= p_ext;
				OP_WAH_WET: x_q   <= sat48(acc_q + p_ext);
				OP_FMT_DRY: acc_q <= p_ext;
				OP_FMT_WET: res_q[ch_q] <= to_sample(sat48(acc_q + p_ext));
				default: ;
			endcase
		end
		// The wah keeps its input for the blend; every other section feeds the next.
		if ((state_q == ST_WR2) && (sec_q != SEC_W'(1)))
			x_q <= y_q;
		if (state_q == ST_OUT && out_free) begin
			left_q  <= res_q[0];
			right_q <= res_q[1];
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;

	ffc_ram #(
		.WIDTH(COEF_BITS),
		.DEPTH(TABLE_WORDS)
	) u_coef_ram (
		.clk  (clk),
		.we   (coef_we),
		.waddr(coef_waddr),
		.wdata(coef_value),
		.raddr(coef_raddr),
		.rdata(coef_rdata)
	);

	ffc_ram #(
		.WIDTH(STATE_BITS),
		.DEPTH(DLY_WORDS)
	) u_dly_ram (
		.clk  (clk),
		.we   (dly_we),
		.waddr(dly_waddr),
		.wdata(dly_wdata),
		.raddr(dly_raddr),
		.rdata(dly_rdata)
	);

	ffc_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.rsp   (mrsp)
	);

endmodule

FILE: design/ffc_checker.sv
`timescale 1ns / 1ps
`include "formant_filter_chain_defines.svh"
module ffc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            operation,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [ffc_pkg::SAMPLE_BITS-1:0] left_out,
	input logic [ffc_pkg::SAMPLE_BITS-1:0] right_out
);

	`FFC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "output item dropped")
	`FFC_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(left_out) && $stable(right_out), "stalled output changed")
	`FFC_ASSERT_NXT(a_busy_after_sample, in_valid && in_ready && !operation, !in_ready, "ready right after a sample item")
	`FFC_ASSERT_NXT(a_write_one_cycle, in_valid && in_ready && operation, in_ready, "coefficient write stalled input")
	`FFC_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(!in_ready), "result appeared while idle")

endmodule

bind formant_filter_chain ffc_checker u_ffc_checker (.*);
